FILE: rtl/rti_pkg.sv
package rti_pkg;

   // coordinate format
   localparam int CW = 16;
   localparam int T_FRAC = 16;
   localparam int QW = 32;

   // derived widths of the exact intermediate values
   localparam int EW = CW + 1;
   localparam int NW = 2 * EW + 1;
   localparam int DENW = NW + CW + 2;
   localparam int NUMW = NW + EW + 2;
   localparam int MW = NW + EW + 1;
   localparam int GW = MW + CW + 2;
   localparam int HW = MW + EW + 2;
   localparam int REMW = NUMW + T_FRAC;
   localparam int DWW = DENW + QW;
   localparam int CHW = (GW + 2) / 3;
   localparam int FW = QW + 3 * CHW + 2;
   localparam int VW = FW + 1;

   // port widths
   localparam int REQ_W = ((6 * CW + 7) / 8) * 8;
   localparam int RSP_DATA_W = QW;
   localparam int RSP_USER_W = 3;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W = 3 * CW;
   localparam int THR_W = 32;

   typedef logic signed [CW-1:0] coord_type;
   typedef logic signed [EW-1:0] diff_type;
   typedef logic signed [2*EW-1:0] np_type;
   typedef logic signed [NW-1:0] n_type;
   typedef logic signed [NW+CW-1:0] dp_type;
   typedef logic signed [NW+EW-1:0] ap_type;
   typedef logic signed [DENW-1:0] den_type;
   typedef logic signed [NUMW-1:0] num_type;
   typedef logic [DENW-1:0] mag_type;
   typedef logic [NUMW-1:0] nmag_type;
   typedef logic signed [MW-1:0] m_type;
   typedef logic signed [MW+CW-1:0] gp_type;
   typedef logic signed [MW+EW-1:0] hp_type;
   typedef logic signed [GW-1:0] g_type;
   typedef logic signed [HW-1:0] h_type;
   typedef logic [QW-1:0] q_type;
   typedef logic [REMW-1:0] rem_type;
   typedef logic [DWW-1:0] dwide_type;
   typedef logic [THR_W-1:0] thr_type;
   typedef logic signed [3*CHW-1:0] gext_type;
   typedef logic [QW+CHW-1:0] pl_type;
   typedef logic signed [QW+CHW:0] ph_type;
   typedef logic signed [FW-1:0] f_type;
   typedef logic signed [VW-1:0] v_type;

   typedef enum logic [1:0] {
      OUTCOME_HIT      = 2'd0,
      OUTCOME_PARALLEL = 2'd1,
      OUTCOME_BEHIND   = 2'd2,
      OUTCOME_OUTSIDE  = 2'd3
   } outcome_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VERTEX_A  = 2'd0,
      CSR_VERTEX_B  = 2'd1,
      CSR_VERTEX_C  = 2'd2,
      CSR_THRESHOLD = 2'd3
   } csr_index_type;

   // flags and edge terms that ride along with the divider
   typedef struct packed {
      logic  par;
      logic  neg;
      logic  sat;
      g_type g0;
      g_type g1;
      g_type g2;
      h_type h0;
      h_type h1;
      h_type h2;
   } side_type;

endpackage

FILE: rtl/rti_geometry.sv
module rti_geometry (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [rti_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rti_pkg::CSR_W-1:0]      csr_wdata,
   output rti_pkg::coord_type             vtx_o [3][3],
   output rti_pkg::n_type                 nrm_o [3],
   output rti_pkg::m_type                 mrm_o [3][3],
   output rti_pkg::thr_type               thr_o
);

   logic [3*rti_pkg::CW-1:0] va_ff, vb_ff, vc_ff;
   rti_pkg::thr_type         thr_ff;

   rti_pkg::diff_type e1_ff [3][3];
   rti_pkg::diff_type f1_ff [3];
   rti_pkg::np_type   np2_ff [6];
   rti_pkg::diff_type e2_ff [3][3];
   rti_pkg::n_type    n3_ff [3];
   rti_pkg::diff_type e3_ff [3][3];
   rti_pkg::ap_type   mp4_ff [3][6];
   rti_pkg::m_type    m5_ff [3][3];

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff  <= '0;
         vb_ff  <= '0;
         vc_ff  <= '0;
         thr_ff <= rti_pkg::thr_type'(1);
      end else if (csr_wr_en) begin
         unique case (rti_pkg::csr_index_type'(csr_index))
            rti_pkg::CSR_VERTEX_A:  va_ff  <= csr_wdata[3*rti_pkg::CW-1:0];
            rti_pkg::CSR_VERTEX_B:  vb_ff  <= csr_wdata[3*rti_pkg::CW-1:0];
            rti_pkg::CSR_VERTEX_C:  vc_ff  <= csr_wdata[3*rti_pkg::CW-1:0];
            rti_pkg::CSR_THRESHOLD: thr_ff <= csr_wdata[rti_pkg::THR_W-1:0];
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vtx_o[0][i] = va_ff[i*rti_pkg::CW +: rti_pkg::CW];
         vtx_o[1][i] = vb_ff[i*rti_pkg::CW +: rti_pkg::CW];
         vtx_o[2][i] = vc_ff[i*rti_pkg::CW +: rti_pkg::CW];
      end
   end

   // derived geometry follows a write through registered edge, product, normal and edge-vector stages
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         e1_ff[0][i] <= rti_pkg::diff_type'(vtx_o[1][i]) - rti_pkg::diff_type'(vtx_o[0][i]);
         e1_ff[1][i] <= rti_pkg::diff_type'(vtx_o[2][i]) - rti_pkg::diff_type'(vtx_o[1][i]);
         e1_ff[2][i] <= rti_pkg::diff_type'(vtx_o[0][i]) - rti_pkg::diff_type'(vtx_o[2][i]);
         f1_ff[i]    <= rti_pkg::diff_type'(vtx_o[2][i]) - rti_pkg::diff_type'(vtx_o[0][i]);
      end
      np2_ff[0] <= rti_pkg::np_type'(e1_ff[0][1]) * rti_pkg::np_type'(f1_ff[2]);
      np2_ff[1] <= rti_pkg::np_type'(e1_ff[0][2]) * rti_pkg::np_type'(f1_ff[1]);
      np2_ff[2] <= rti_pkg::np_type'(e1_ff[0][2]) * rti_pkg::np_type'(f1_ff[0]);
      np2_ff[3] <= rti_pkg::np_type'(e1_ff[0][0]) * rti_pkg::np_type'(f1_ff[2]);
      np2_ff[4] <= rti_pkg::np_type'(e1_ff[0][0]) * rti_pkg::np_type'(f1_ff[1]);
      np2_ff[5] <= rti_pkg::np_type'(e1_ff[0][1]) * rti_pkg::np_type'(f1_ff[0]);
      e2_ff <= e1_ff;
      for (int i = 0; i < 3; i++) begin
         n3_ff[i] <= rti_pkg::n_type'(np2_ff[2*i]) - rti_pkg::n_type'(np2_ff[2*i+1]);
      end
      e3_ff <= e2_ff;
      // per-edge vector n x e, so the edge test becomes a dot product
      for (int k = 0; k < 3; k++) begin
         mp4_ff[k][0] <= rti_pkg::ap_type'(n3_ff[1]) * rti_pkg::ap_type'(e3_ff[k][2]);
         mp4_ff[k][1] <= rti_pkg::ap_type'(n3_ff[2]) * rti_pkg::ap_type'(e3_ff[k][1]);
         mp4_ff[k][2] <= rti_pkg::ap_type'(n3_ff[2]) * rti_pkg::ap_type'(e3_ff[k][0]);
         mp4_ff[k][3] <= rti_pkg::ap_type'(n3_ff[0]) * rti_pkg::ap_type'(e3_ff[k][2]);
         mp4_ff[k][4] <= rti_pkg::ap_type'(n3_ff[0]) * rti_pkg::ap_type'(e3_ff[k][1]);
         mp4_ff[k][5] <= rti_pkg::ap_type'(n3_ff[1]) * rti_pkg::ap_type'(e3_ff[k][0]);
         for (int i = 0; i < 3; i++) begin
            m5_ff[k][i] <= rti_pkg::m_type'(mp4_ff[k][2*i]) - rti_pkg::m_type'(mp4_ff[k][2*i+1]);
         end
      end
   end

   assign nrm_o = n3_ff;
   assign mrm_o = m5_ff;
   assign thr_o = thr_ff;

endmodule

FILE: rtl/rti_front.sv
module rti_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [rti_pkg::REQ_W-1:0]     in_data,
   input  rti_pkg::coord_type            vtx [3][3],
   input  rti_pkg::n_type                nrm [3],
   input  rti_pkg::m_type                mrm [3][3],
   input  rti_pkg::thr_type              thr,
   output logic                          out_valid,
   input  logic                          out_ready,
   output rti_pkg::rem_type              out_rem,
   output rti_pkg::mag_type              out_dd,
   output rti_pkg::side_type             out_side
);

   localparam int NS = 8;

   logic v_ff [NS];
   logic en [NS];

   rti_pkg::coord_type o1_ff [3], d1_ff [3];
   rti_pkg::coord_type o2_ff [3], d2_ff [3];
   rti_pkg::coord_type o3_ff [3], d3_ff [3];
   rti_pkg::diff_type  ao4_ff [3], w4_ff [3][3];
   rti_pkg::coord_type d4_ff [3];
   rti_pkg::dp_type    dp5_ff [3];
   rti_pkg::ap_type    ap5_ff [3];
   rti_pkg::diff_type  w5_ff [3][3];
   rti_pkg::coord_type d5_ff [3];
   rti_pkg::den_type   den6_ff;
   rti_pkg::num_type   num6_ff;
   rti_pkg::diff_type  w6_ff [3][3];
   rti_pkg::coord_type d6_ff [3];
   rti_pkg::mag_type   mden7_ff;
   rti_pkg::nmag_type  mnum7_ff;
   logic               zero7_ff, neg7_ff;
   rti_pkg::gp_type    gp7_ff [3][3];
   rti_pkg::hp_type    hp7_ff [3][3];
   rti_pkg::rem_type   rem8_ff;
   rti_pkg::mag_type   dd8_ff;
   rti_pkg::side_type  side8_ff;

   rti_pkg::side_type  side8_in;

   always_comb begin
      en[NS-1] = !v_ff[NS-1] || out_ready;
      for (int k = NS - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign in_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NS; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else begin
         if (en[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k < NS; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int i = 0; i < 3; i++) begin
            o1_ff[i] <= in_data[i*rti_pkg::CW +: rti_pkg::CW];
            d1_ff[i] <= in_data[(3+i)*rti_pkg::CW +: rti_pkg::CW];
         end
      end
      if (en[1]) begin
         o2_ff <= o1_ff;
         d2_ff <= d1_ff;
      end
      if (en[2]) begin
         o3_ff <= o2_ff;
         d3_ff <= d2_ff;
      end
      if (en[3]) begin
         for (int i = 0; i < 3; i++) begin
            ao4_ff[i] <= rti_pkg::diff_type'(vtx[0][i]) - rti_pkg::diff_type'(o3_ff[i]);
            for (int k = 0; k < 3; k++) begin
               w4_ff[k][i] <= rti_pkg::diff_type'(o3_ff[i]) - rti_pkg::diff_type'(vtx[k][i]);
            end
         end
         d4_ff <= d3_ff;
      end
      if (en[4]) begin
         for (int i = 0; i < 3; i++) begin
            dp5_ff[i] <= rti_pkg::dp_type'(nrm[i]) * rti_pkg::dp_type'(d4_ff[i]);
            ap5_ff[i] <= rti_pkg::ap_type'(nrm[i]) * rti_pkg::ap_type'(ao4_ff[i]);
         end
         w5_ff <= w4_ff;
         d5_ff <= d4_ff;
      end
      if (en[5]) begin
         den6_ff <= rti_pkg::den_type'(dp5_ff[0]) + rti_pkg::den_type'(dp5_ff[1])
                  + rti_pkg::den_type'(dp5_ff[2]);
         num6_ff <= rti_pkg::num_type'(ap5_ff[0]) + rti_pkg::num_type'(ap5_ff[1])
                  + rti_pkg::num_type'(ap5_ff[2]);
         w6_ff <= w5_ff;
         d6_ff <= d5_ff;
      end
      if (en[6]) begin
         mden7_ff <= den6_ff[rti_pkg::DENW-1] ? rti_pkg::mag_type'(-den6_ff)
                                               : rti_pkg::mag_type'(den6_ff);
         mnum7_ff <= num6_ff[rti_pkg::NUMW-1] ? rti_pkg::nmag_type'(-num6_ff)
                                               : rti_pkg::nmag_type'(num6_ff);
         zero7_ff <= (den6_ff == '0);
         neg7_ff  <= (num6_ff != '0) && (num6_ff[rti_pkg::NUMW-1] != den6_ff[rti_pkg::DENW-1]);
         for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
               gp7_ff[k][i] <= rti_pkg::gp_type'(mrm[k][i]) * rti_pkg::gp_type'(d6_ff[i]);
               hp7_ff[k][i] <= rti_pkg::hp_type'(mrm[k][i]) * rti_pkg::hp_type'(w6_ff[k][i]);
            end
         end
      end
      if (en[7]) begin
         rem8_ff  <= rti_pkg::rem_type'(mnum7_ff) << rti_pkg::T_FRAC;
         dd8_ff   <= mden7_ff;
         side8_ff <= side8_in;
      end
   end

   // t saturates once |num| reaches |den| scaled by 2^16
   always_comb begin
      side8_in.par = zero7_ff || (mden7_ff < rti_pkg::mag_type'(thr));
      side8_in.neg = neg7_ff;
      side8_in.sat = rti_pkg::rem_type'(mnum7_ff)
                     >= (rti_pkg::rem_type'(mden7_ff) << rti_pkg::T_FRAC);
      side8_in.g0 = rti_pkg::g_type'(gp7_ff[0][0]) + rti_pkg::g_type'(gp7_ff[0][1])
                  + rti_pkg::g_type'(gp7_ff[0][2]);
      side8_in.g1 = rti_pkg::g_type'(gp7_ff[1][0]) + rti_pkg::g_type'(gp7_ff[1][1])
                  + rti_pkg::g_type'(gp7_ff[1][2]);
      side8_in.g2 = rti_pkg::g_type'(gp7_ff[2][0]) + rti_pkg::g_type'(gp7_ff[2][1])
                  + rti_pkg::g_type'(gp7_ff[2][2]);
      side8_in.h0 = rti_pkg::h_type'(hp7_ff[0][0]) + rti_pkg::h_type'(hp7_ff[0][1])
                  + rti_pkg::h_type'(hp7_ff[0][2]);
      side8_in.h1 = rti_pkg::h_type'(hp7_ff[1][0]) + rti_pkg::h_type'(hp7_ff[1][1])
                  + rti_pkg::h_type'(hp7_ff[1][2]);
      side8_in.h2 = rti_pkg::h_type'(hp7_ff[2][0]) + rti_pkg::h_type'(hp7_ff[2][1])
                  + rti_pkg::h_type'(hp7_ff[2][2]);
   end

   assign out_valid = v_ff[NS-1];
   assign out_rem   = rem8_ff;
   assign out_dd    = dd8_ff;
   assign out_side  = side8_ff;

endmodule

FILE: rtl/rti_divider.sv
module rti_divider (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  rti_pkg::rem_type   in_rem,
   input  rti_pkg::mag_type   in_dd,
   input  rti_pkg::side_type  in_side,
   output logic               out_valid,
   input  logic               out_ready,
   output rti_pkg::q_type     out_q,
   output rti_pkg::side_type  out_side
);

   localparam int NS = rti_pkg::QW;

   logic              v_ff [NS];
   logic              en [NS];
   rti_pkg::rem_type  rem_ff [NS];
   rti_pkg::mag_type  dd_ff [NS];
   rti_pkg::q_type    q_ff [NS];
   rti_pkg::side_type side_ff [NS];

   logic              v_src [NS];
   rti_pkg::rem_type  rem_src [NS];
   rti_pkg::mag_type  dd_src [NS];
   rti_pkg::q_type    q_src [NS];
   rti_pkg::side_type side_src [NS];
   rti_pkg::rem_type  rem_in [NS];
   rti_pkg::q_type    q_in [NS];

   always_comb begin
      en[NS-1] = !v_ff[NS-1] || out_ready;
      for (int k = NS - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign in_ready = en[0];

   always_comb begin
      v_src[0]    = in_valid;
      rem_src[0]  = in_rem;
      dd_src[0]   = in_dd;
      q_src[0]    = '0;
      side_src[0] = in_side;
      for (int k = 1; k < NS; k++) begin
         v_src[k]    = v_ff[k-1];
         rem_src[k]  = rem_ff[k-1];
         dd_src[k]   = dd_ff[k-1];
         q_src[k]    = q_ff[k-1];
         side_src[k] = side_ff[k-1];
      end
   end

   // one quotient bit a stage, msb first, restoring
   for (genvar k = 0; k < NS; k++) begin : g_step
      rti_pkg::dwide_type trial;
      rti_pkg::dwide_type cur;
      assign trial = rti_pkg::dwide_type'(dd_src[k]) << (NS - 1 - k);
      assign cur   = rti_pkg::dwide_type'(rem_src[k]);
      always_comb begin
         rem_in[k] = rem_src[k];
         q_in[k]   = q_src[k];
         if (cur >= trial) begin
            rem_in[k]         = rti_pkg::rem_type'(cur - trial);
            q_in[k][NS-1-k]   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NS; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_src[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NS; k++) begin
         if (en[k]) begin
            rem_ff[k]  <= rem_in[k];
            dd_ff[k]   <= dd_src[k];
            q_ff[k]    <= q_in[k];
            side_ff[k] <= side_src[k];
         end
      end
   end

   assign out_valid = v_ff[NS-1];
   assign out_q     = q_ff[NS-1];
   assign out_side  = side_ff[NS-1];

endmodule

FILE: rtl/rti_back.sv
module rti_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  rti_pkg::q_type        in_q,
   input  rti_pkg::side_type     in_side,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic                  out_hit,
   output rti_pkg::outcome_type  out_outcome,
   output rti_pkg::q_type        out_dist
);

   localparam int NS = 3;
   localparam int CHW = rti_pkg::CHW;

   logic v_ff [NS];
   logic en [NS];

   rti_pkg::q_type   qs1_ff;
   rti_pkg::pl_type  pl1_ff [3][2];
   rti_pkg::ph_type  ph1_ff [3];
   rti_pkg::h_type   h1_ff [3];
   logic             par1_ff, neg1_ff;
   rti_pkg::f_type   f2_ff [3];
   rti_pkg::h_type   h2_ff [3];
   rti_pkg::q_type   qs2_ff;
   logic             par2_ff, neg2_ff;
   logic             hit_ff;
   rti_pkg::outcome_type outcome_ff;
   rti_pkg::q_type   dist_ff;

   rti_pkg::q_type   qs_in;
   rti_pkg::gext_type gx [3];
   rti_pkg::v_type   vv [3];
   logic             behind, outside;
   logic             hit_in;
   rti_pkg::outcome_type outcome_in;
   rti_pkg::q_type   dist_in;

   always_comb begin
      en[NS-1] = !v_ff[NS-1] || out_ready;
      for (int k = NS - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign in_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NS; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else begin
         if (en[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k < NS; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // saturated t also places the point
   assign qs_in = in_side.sat ? '1 : in_q;

   always_comb begin
      gx[0] = rti_pkg::gext_type'(in_side.g0);
      gx[1] = rti_pkg::gext_type'(in_side.g1);
      gx[2] = rti_pkg::gext_type'(in_side.g2);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         qs1_ff  <= qs_in;
         par1_ff <= in_side.par;
         neg1_ff <= in_side.neg;
         h1_ff[0] <= in_side.h0;
         h1_ff[1] <= in_side.h1;
         h1_ff[2] <= in_side.h2;
         for (int k = 0; k < 3; k++) begin
            pl1_ff[k][0] <= rti_pkg::pl_type'(qs_in) * rti_pkg::pl_type'(gx[k][CHW-1:0]);
            pl1_ff[k][1] <= rti_pkg::pl_type'(qs_in) * rti_pkg::pl_type'(gx[k][2*CHW-1:CHW]);
            ph1_ff[k]    <= rti_pkg::ph_type'(signed'({1'b0, qs_in}))
                          * rti_pkg::ph_type'(signed'(gx[k][3*CHW-1:2*CHW]));
         end
      end
      if (en[1]) begin
         for (int k = 0; k < 3; k++) begin
            f2_ff[k] <= rti_pkg::f_type'(pl1_ff[k][0])
                      + (rti_pkg::f_type'(pl1_ff[k][1]) << CHW)
                      + (rti_pkg::f_type'(ph1_ff[k]) << (2 * CHW));
         end
         h2_ff   <= h1_ff;
         qs2_ff  <= qs1_ff;
         par2_ff <= par1_ff;
         neg2_ff <= neg1_ff;
      end
      if (en[2]) begin
         hit_ff     <= hit_in;
         outcome_ff <= outcome_in;
         dist_ff    <= dist_in;
      end
   end

   // edge test sign: 2^16 * m.(o - s) + t * m.d
   always_comb begin
      outside = 1'b0;
      for (int k = 0; k < 3; k++) begin
         vv[k] = rti_pkg::v_type'(f2_ff[k]) + (rti_pkg::v_type'(h2_ff[k]) << rti_pkg::T_FRAC);
         outside = outside | vv[k][rti_pkg::VW-1];
      end
      behind = neg2_ff && (qs2_ff != '0);
      hit_in = 1'b0;
      dist_in = qs2_ff;
      if (par2_ff) begin
         outcome_in = rti_pkg::OUTCOME_PARALLEL;
         dist_in    = '0;
      end else if (behind) begin
         outcome_in = rti_pkg::OUTCOME_BEHIND;
         dist_in    = '0;
      end else if (outside) begin
         outcome_in = rti_pkg::OUTCOME_OUTSIDE;
      end else begin
         outcome_in = rti_pkg::OUTCOME_HIT;
         hit_in     = 1'b1;
      end
   end

   assign out_valid   = v_ff[NS-1];
   assign out_hit     = hit_ff;
   assign out_outcome = outcome_ff;
   assign out_dist    = dist_ff;

endmodule

FILE: rtl/ray_triangle_intersect.sv
// a ray accepted at a clock edge gives its result on rsp after passing through the
// setup and dot-product stages, the divider stages and the edge-test stages
// throughput: one ray per clock unless rsp_tready holds the output back; the divider is pipelined, one bit per stage
// reset: synchronous; clears every stage valid bit, vertices to 0, threshold to 1
// derived normal and edge vectors follow a register write through the registered geometry stages
module ray_triangle_intersect (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
   input  logic [rti_pkg::REQ_W-1:0]          req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // hit_distance
   output logic [rti_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // hit, outcome
   output logic [rti_pkg::RSP_USER_W-1:0]     rsp_tuser,
   input  logic                               csr_wr_en,
   input  logic [rti_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rti_pkg::CSR_W-1:0]          csr_wdata
);

   rti_pkg::coord_type vtx [3][3];
   rti_pkg::n_type     nrm [3];
   rti_pkg::m_type     mrm [3][3];
   rti_pkg::thr_type   thr;

   logic              fr_valid, fr_ready;
   rti_pkg::rem_type  fr_rem;
   rti_pkg::mag_type  fr_dd;
   rti_pkg::side_type fr_side;

   logic              dv_valid, dv_ready;
   rti_pkg::q_type    dv_q;
   rti_pkg::side_type dv_side;

   logic                 out_hit;
   rti_pkg::outcome_type out_outcome;
   rti_pkg::q_type       out_dist;

   rti_geometry u_geometry (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .vtx_o     (vtx),
      .nrm_o     (nrm),
      .mrm_o     (mrm),
      .thr_o     (thr)
   );

   rti_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_tdata),
      .vtx       (vtx),
      .nrm       (nrm),
      .mrm       (mrm),
      .thr       (thr),
      .out_valid (fr_valid),
      .out_ready (fr_ready),
      .out_rem   (fr_rem),
      .out_dd    (fr_dd),
      .out_side  (fr_side)
   );

   rti_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_rem    (fr_rem),
      .in_dd     (fr_dd),
      .in_side   (fr_side),
      .out_valid (dv_valid),
      .out_ready (dv_ready),
      .out_q     (dv_q),
      .out_side  (dv_side)
   );

   rti_back u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (dv_valid),
      .in_ready    (dv_ready),
      .in_q        (dv_q),
      .in_side     (dv_side),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_hit     (out_hit),
      .out_outcome (out_outcome),
      .out_dist    (out_dist)
   );

   assign rsp_tdata = out_dist;
   assign rsp_tuser = {out_outcome, out_hit};

`ifndef SYNTHESIS
   // only a stalled output word can hold the input back
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("input stalled without a stalled output word");

   a_reject_dist: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (out_outcome == rti_pkg::OUTCOME_PARALLEL
                      || out_outcome == rti_pkg::OUTCOME_BEHIND)) |-> (rsp_tdata == '0))
      else $error("distance not cleared on parallel or behind");

   a_hit_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (out_hit == (out_outcome == rti_pkg::OUTCOME_HIT)))
      else $error("hit flag disagrees with outcome");

   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_tvalid)
      else $error("output valid straight after reset");
`endif

endmodule

FILE: dv/ray_triangle_intersect_tb.sv
module ray_triangle_intersect_tb;

   typedef logic signed [127:0] big_type;
   typedef big_type vec_type [3];

   typedef struct {
      logic                 hit;
      rti_pkg::outcome_type outcome;
      logic [31:0]          distance;
   } verdict_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [rti_pkg::REQ_W-1:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [rti_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [rti_pkg::RSP_USER_W-1:0] rsp_tuser;
   logic csr_wr_en;
   logic [rti_pkg::CSR_IDX_W-1:0] csr_index;
   logic [rti_pkg::CSR_W-1:0] csr_wdata;

   // testbench copy of the triangle registers
   logic [47:0] tri_reg [3];
   logic [31:0] threshold;
   int tri_v [3][3];

   logic [rti_pkg::REQ_W-1:0] rays_pending [$];
   verdict_type expected_hits [$];
   int failures;
   int idle_cycles;
   int req_gap;
   int rsp_gap;
   bit burst_mode;

   ray_triangle_intersect dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic vec_type vsub(vec_type a, vec_type b);
      vec_type r;
      for (int i = 0; i < 3; i++) r[i] = a[i] - b[i];
      return r;
   endfunction

   function automatic vec_type vcross(vec_type a, vec_type b);
      vec_type r;
      r[0] = a[1] * b[2] - a[2] * b[1];
      r[1] = a[2] * b[0] - a[0] * b[2];
      r[2] = a[0] * b[1] - a[1] * b[0];
      return r;
   endfunction

   function automatic big_type vdot(vec_type a, vec_type b);
      return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
   endfunction

   function automatic vec_type unpack_vertex(logic [47:0] r);
      vec_type v;
      for (int i = 0; i < 3; i++) v[i] = big_type'($signed(r[16*i +: 16]));
      return v;
   endfunction

   function automatic verdict_type intersect_ray(logic [rti_pkg::REQ_W-1:0] w);
      verdict_type res;
      vec_type o, d, a, b, c, n, p, sa, sb, sc;
      big_type den, mden, num, mnum, scaled, q;
      logic neg;
      for (int i = 0; i < 3; i++) begin
         o[i] = big_type'($signed(w[16*i +: 16]));
         d[i] = big_type'($signed(w[16*(3+i) +: 16]));
      end
      a = unpack_vertex(tri_reg[0]);
      b = unpack_vertex(tri_reg[1]);
      c = unpack_vertex(tri_reg[2]);
      n = vcross(vsub(b, a), vsub(c, a));
      den = vdot(n, d);
      mden = den < 0 ? -den : den;
      res.hit = 1'b0;
      res.distance = 32'd0;
      if (den == 0 || mden < $signed({96'b0, threshold})) begin
         res.outcome = rti_pkg::OUTCOME_PARALLEL;
         return res;
      end
      num = vdot(n, vsub(a, o));
      neg = num != 0 && ((num < 0) != (den < 0));
      mnum = num < 0 ? -num : num;
      scaled = mnum <<< 16;
      if (scaled >= (mden <<< 32)) q = 128'hFFFF_FFFF;
      else q = scaled / mden;
      if (neg && q != 0) begin
         res.outcome = rti_pkg::OUTCOME_BEHIND;
         return res;
      end
      res.distance = q[31:0];
      for (int i = 0; i < 3; i++) begin
         p[i] = o[i] * 65536 + d[i] * q;
         sa[i] = a[i] * 65536;
         sb[i] = b[i] * 65536;
         sc[i] = c[i] * 65536;
      end
      // a zero edge test counts as inside
      if (vdot(n, vcross(vsub(b, a), vsub(p, sa))) < 0 ||
          vdot(n, vcross(vsub(c, b), vsub(p, sb))) < 0 ||
          vdot(n, vcross(vsub(a, c), vsub(p, sc))) < 0) begin
         res.outcome = rti_pkg::OUTCOME_OUTSIDE;
         return res;
      end
      res.hit = 1'b1;
      res.outcome = rti_pkg::OUTCOME_HIT;
      return res;
   endfunction

   function automatic logic [rti_pkg::REQ_W-1:0] pack_ray(int ox, int oy, int oz,
                                                           int dx, int dy, int dz);
      logic [15:0] f [6];
      f[0] = 16'(ox); f[1] = 16'(oy); f[2] = 16'(oz);
      f[3] = 16'(dx); f[4] = 16'(dy); f[5] = 16'(dz);
      return {f[5], f[4], f[3], f[2], f[1], f[0]};
   endfunction

   // mostly short gaps, now and then a long one, none at all in burst mode
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (burst_mode || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_tvalid <= 1'b0;
         end else if (rays_pending.size() > 0) begin
            req_tdata <= rays_pending.pop_front();
            req_tvalid <= 1'b1;
            req_gap <= pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor: predicts on accepted rays, checks accepted results
   always @(posedge clock) begin
      verdict_type e;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_gap <= 0;
      end else begin
         if (req_tvalid && req_tready) expected_hits.push_back(intersect_ray(req_tdata));
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            rsp_gap <= pick_gap();
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_hits.size() == 0) begin
               $display("%0t: unexpected word hit=%b outcome=%0d t=%h", $time,
                        rsp_tuser[0], rsp_tuser[2:1], rsp_tdata);
               failures++;
            end else begin
               e = expected_hits.pop_front();
               if (rsp_tuser[0] !== e.hit) begin
                  $display("%0t: hit expected %b actual %b", $time, e.hit, rsp_tuser[0]);
                  failures++;
               end
               if (rsp_tuser[2:1] !== e.outcome) begin
                  $display("%0t: outcome expected %0d actual %0d", $time,
                           e.outcome, rsp_tuser[2:1]);
                  failures++;
               end
               if (rsp_tdata !== e.distance) begin
                  $display("%0t: hit_distance expected %h actual %h", $time,
                           e.distance, rsp_tdata);
                  failures++;
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic wait_idle();
      wait (rays_pending.size() == 0 && !req_tvalid && expected_hits.size() == 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic load_triangle(int v [3][3], logic [47:0] thr_word);
      logic [47:0] w;
      for (int k = 0; k < 3; k++) begin
         w = {16'(v[k][2]), 16'(v[k][1]), 16'(v[k][0])};
         tri_reg[k] = w;
         for (int i = 0; i < 3; i++) tri_v[k][i] = int'($signed(w[16*i +: 16]));
         @(posedge clock);
         csr_wr_en <= 1'b1;
         csr_index <= rti_pkg::csr_index_type'(k);
         csr_wdata <= w;
      end
      threshold = thr_word[31:0];
      @(posedge clock);
      csr_index <= rti_pkg::CSR_THRESHOLD;
      csr_wdata <= thr_word;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      // wait for the derived normal to settle through the geometry registers
      repeat (8) @(posedge clock);
   endtask

   function automatic int rnd_coord(int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   initial begin
      int v [3][3];
      int u, w, s, o [3], t [3], r;
      logic [47:0] thr_word;
      failures = 0;
      burst_mode = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = rti_pkg::CSR_VERTEX_A;
      csr_wdata = '0;
      tri_reg[0] = '0; tri_reg[1] = '0; tri_reg[2] = '0;
      threshold = 32'd1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset triangle is degenerate, every ray is parallel
      rays_pending.push_back({96{1'b0}});
      rays_pending.push_back({96{1'b1}});
      rays_pending.push_back(pack_ray(32767, 32767, 32767, 32767, 32767, 32767));
      rays_pending.push_back(pack_ray(-32768, -32768, -32768, -32768, -32768, -32768));
      wait_idle();

      v = '{'{0, 0, 0}, '{256, 0, 0}, '{0, 256, 0}};
      load_triangle(v, 48'h1);
      rays_pending.push_back(pack_ray(64, 64, 256, 0, 0, -256));      // plain hit
      rays_pending.push_back(pack_ray(64, 64, 256, 0, 0, 256));       // behind
      rays_pending.push_back(pack_ray(64, 64, 256, 256, 0, 0));       // in-plane
      rays_pending.push_back(pack_ray(64, 64, 256, 0, 0, 0));         // zero direction
      rays_pending.push_back(pack_ray(128, 0, 256, 0, 0, -256));      // on an edge
      rays_pending.push_back(pack_ray(0, 0, 256, 0, 0, -256));        // on a corner
      rays_pending.push_back(pack_ray(300, 300, 256, 0, 0, -256));    // outside
      rays_pending.push_back(pack_ray(10, 10, 32767, 0, 0, -1));      // far hit
      rays_pending.push_back(pack_ray(10, 10, -32768, 0, 0, 1));      // far from below
      rays_pending.push_back(pack_ray(10, 10, 0, 0, 0, 1));           // origin in plane
      rays_pending.push_back(pack_ray(10, 10, 1, 32767, 32767, -1));  // steep and far
      rays_pending.push_back(pack_ray(32767, -32768, 5, -32768, 32767, -32768));
      wait_idle();
      // zero threshold still treats a zero denominator as parallel
      load_triangle(v, 48'h0);
      rays_pending.push_back(pack_ray(64, 64, 256, 256, 0, 0));
      rays_pending.push_back(pack_ray(64, 64, 256, 0, 0, -1));
      wait_idle();

      for (int ph = 0; ph < 8; ph++) begin
         for (int k = 0; k < 3; k++)
            for (int i = 0; i < 3; i++)
               v[k][i] = ph == 3 ? int'($signed(16'($urandom))) : rnd_coord(2048);
         case (ph)
            0: thr_word = 48'h0;
            1: thr_word = {16'($urandom), 32'hFFFF_FFFF};
            2: thr_word = 48'h1;
            4: thr_word = {16'($urandom), $urandom};
            default: thr_word = 48'($urandom_range(0, 1 << 20));
         endcase
         load_triangle(v, thr_word);
         burst_mode = ph % 3 == 2;
         for (int n = 0; n < 160; n++) begin
            r = $urandom_range(0, 99);
            if (r < 25) begin
               rays_pending.push_back({$urandom, $urandom, $urandom});
            end else begin
               // aim at a point in (or just around) the triangle
               u = $urandom_range(0, 300);
               w = $urandom_range(0, 300 - u);
               s = 1 << $urandom_range(0, 2);
               for (int i = 0; i < 3; i++) begin
                  o[i] = rnd_coord(8192);
                  t[i] = tri_v[0][i] + ((tri_v[1][i] - tri_v[0][i]) * u
                         + (tri_v[2][i] - tri_v[0][i]) * w) / 256;
                  t[i] = (t[i] - o[i]) / s;
                  if (t[i] > 32767) t[i] = 32767;
                  if (t[i] < -32768) t[i] = -32768;
                  if (r < 35) t[i] = -t[i];
               end
               rays_pending.push_back(pack_ray(o[0], o[1], o[2], t[0], t[1], t[2]));
            end
         end
         wait_idle();
      end

      repeat (60) @(posedge clock);
      if (failures == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
